// ----- rtl/lrks_pkg.sv -----
// Shared types and constants for the LRU link key store.
package lrks_pkg;

  localparam int ADDR_W  = 48;
  localparam int KEY_W   = 64;
  localparam int KKIND_W = 8;
  localparam int DATA_W  = ADDR_W + 2 * KEY_W + KKIND_W;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Per-entry verdict of the shared compare unit.
  typedef struct packed {
    logic match;
    logic below;
    logic above;
  } unit_flags_t;

endpackage

// ----- rtl/lrks_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lrks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lrks_unit.sv -----
// Shared per-entry unit: address match, rank compares and rank step.
module lrks_unit #(
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                       entry_valid,
  input  logic [lrks_pkg::ADDR_W-1:0] entry_addr,
  input  logic [lrks_pkg::ADDR_W-1:0] key_addr,
  input  logic [IW-1:0]              rank,
  input  logic [CW-1:0]              limit,
  input  logic [IW-1:0]              ref_rank,
  input  logic                       down,
  output lrks_pkg::unit_flags_t      flags,
  output logic [IW-1:0]              next_rank
);

  always_comb begin
    flags.match = entry_valid && (entry_addr == key_addr);
    flags.below = entry_valid && ({{(CW-IW){1'b0}}, rank} < limit);
    flags.above = entry_valid && (rank > ref_rank);
    next_rank   = down ? (rank - IW'(1)) : (rank + IW'(1));
  end

endmodule

// ----- rtl/lru_link_key_store.sv -----
// Top level of the LRU link key store: sequencer, entry storage and result registers.
//
// One item is taken when start is high and busy is low. The block then walks the
// table one entry per cycle through the entry RAM read port to find the address, a
// free entry and the least recent entry, and, when the item changes the table, walks
// the rank RAM once more to rewrite the recency ranks. An item that leaves the table
// unchanged (a miss, a delete miss, an unused kind) goes from the scan through the
// decide state to its result; one that changes it adds the rank walk; busy falls
// in the cycle after the result. Each item gives exactly one result, shown for one
// cycle with out_strobe high; the receiver cannot stall it. The valid bits clear at
// reset, so the table is empty at once and no clearing pass is needed.
module lru_link_key_store #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [lrks_pkg::ADDR_W-1:0]   in_device_address,
  input  logic [lrks_pkg::KEY_W-1:0]    in_key_upper,
  input  logic [lrks_pkg::KEY_W-1:0]    in_key_lower,
  input  logic [lrks_pkg::KKIND_W-1:0]  in_key_kind,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic [lrks_pkg::KEY_W-1:0]    out_key_upper,
  output logic [lrks_pkg::KEY_W-1:0]    out_key_lower,
  output logic [lrks_pkg::KKIND_W-1:0]  out_key_kind
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(ENTRIES);

  lrks_pkg::state_t state_r, state_nxt;

  logic [1:0]                   kind_r;
  logic [lrks_pkg::ADDR_W-1:0]  addr_r;
  logic [lrks_pkg::KEY_W-1:0]   ku_r, kl_r;
  logic [lrks_pkg::KKIND_W-1:0] kk_r;

  logic [CW-1:0] cnt_r;
  logic [ENTRIES-1:0] valid_r;

  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, hit_rank_r, free_idx_r, max_idx_r, max_rank_r;
  logic [lrks_pkg::KEY_W-1:0]   hu_r, hl_r;
  logic [lrks_pkg::KKIND_W-1:0] hk_r;

  logic [IW-1:0] s_r;
  logic [CW-1:0] limit_r;
  logic          down_r;

  logic                          found_r;
  logic [lrks_pkg::KEY_W-1:0]    ou_r, ol_r;
  logic [lrks_pkg::KKIND_W-1:0]  ok_r;

  // Control decoded from the state.
  logic scan_st, decide_st, update_st, proc;
  logic [CW-1:0] ridx_full;
  logic [IW-1:0] ridx, rd_addr;

  // Decision made at the end of the scan.
  logic          upd;
  logic [IW-1:0] s_nxt;
  logic [CW-1:0] limit_nxt;

  logic [lrks_pkg::DATA_W-1:0] data_rd, data_wr;
  logic                        data_we;
  logic [IW-1:0]               rank_rd, rank_wr, next_rank, ref_rank;
  logic                        rank_we;
  lrks_pkg::unit_flags_t       flags;

  logic [lrks_pkg::ADDR_W-1:0]  e_addr;
  logic [lrks_pkg::KEY_W-1:0]   e_ku, e_kl;
  logic [lrks_pkg::KKIND_W-1:0] e_kk;

  assign {e_addr, e_ku, e_kl, e_kk} = data_rd;
  assign data_wr = {addr_r, ku_r, kl_r, kk_r};

  assign ridx_full = cnt_r - CW'(1);
  assign ridx      = ridx_full[IW-1:0];
  assign rd_addr   = cnt_r[IW-1:0];

  lrks_ram #(.WIDTH(lrks_pkg::DATA_W), .DEPTH(ENTRIES), .AW(IW)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (s_nxt),
    .wdata (data_wr),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  lrks_ram #(.WIDTH(IW), .DEPTH(ENTRIES), .AW(IW)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (ridx),
    .wdata (rank_wr),
    .raddr (rd_addr),
    .rdata (rank_rd)
  );

  assign ref_rank = update_st ? limit_r[IW-1:0] : max_rank_r;

  lrks_unit #(.IW(IW), .CW(CW)) u_unit (
    .entry_valid (valid_r[ridx]),
    .entry_addr  (e_addr),
    .key_addr    (addr_r),
    .rank        (rank_rd),
    .limit       (limit_r),
    .ref_rank    (ref_rank),
    .down        (down_r),
    .flags       (flags),
    .next_rank   (next_rank)
  );

  // Target entry and rank window once the scan is complete.
  always_comb begin
    upd       = 1'b0;
    s_nxt     = hit_idx_r;
    limit_nxt = {{(CW-IW){1'b0}}, hit_rank_r};
    unique case (lrks_pkg::kind_t'(kind_r))
      lrks_pkg::KIND_LOOKUP: upd = hit_r;
      lrks_pkg::KIND_DELETE: upd = hit_r;
      lrks_pkg::KIND_PUT: begin
        upd = 1'b1;
        if (!hit_r && free_r) begin
          // Every valid entry ages when a free entry is taken.
          s_nxt     = free_idx_r;
          limit_nxt = LAST;
        end else if (!hit_r) begin
          s_nxt     = max_idx_r;
          limit_nxt = {{(CW-IW){1'b0}}, max_rank_r};
        end
      end
      default: upd = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrks_pkg::ST_IDLE:   if (start) state_nxt = lrks_pkg::ST_SCAN;
      lrks_pkg::ST_SCAN:   if (cnt_r == LAST) state_nxt = lrks_pkg::ST_DECIDE;
      lrks_pkg::ST_DECIDE: state_nxt = upd ? lrks_pkg::ST_UPDATE : lrks_pkg::ST_DONE;
      lrks_pkg::ST_UPDATE: if (cnt_r == LAST) state_nxt = lrks_pkg::ST_DONE;
      lrks_pkg::ST_DONE:   state_nxt = lrks_pkg::ST_IDLE;
      default:             state_nxt = lrks_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_r != lrks_pkg::ST_IDLE);
    out_strobe = (state_r == lrks_pkg::ST_DONE);
    scan_st    = (state_r == lrks_pkg::ST_SCAN);
    decide_st  = (state_r == lrks_pkg::ST_DECIDE);
    update_st  = (state_r == lrks_pkg::ST_UPDATE);
    // Read data for entry cnt_r-1 is present while cnt_r is past zero.
    proc       = (scan_st || update_st) && (cnt_r != '0);
    data_we    = decide_st && (lrks_pkg::kind_t'(kind_r) == lrks_pkg::KIND_PUT);
    rank_we    = update_st && proc &&
                 ((ridx == s_r) || (flags.below && !down_r) || (flags.above && down_r));
    rank_wr    = (ridx == s_r) ? '0 : next_rank;
  end

  assign out_found     = found_r;
  assign out_key_upper = ou_r;
  assign out_key_lower = ol_r;
  assign out_key_kind  = ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrks_pkg::ST_IDLE;
      cnt_r   <= '0;
      valid_r <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == lrks_pkg::ST_IDLE && start) begin
        kind_r     <= in_kind;
        addr_r     <= in_device_address;
        ku_r       <= in_key_upper;
        kl_r       <= in_key_lower;
        kk_r       <= in_key_kind;
        cnt_r      <= '0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
        max_idx_r  <= '0;
        max_rank_r <= '0;
      end

      if (scan_st || update_st) begin
        cnt_r <= (cnt_r == LAST) ? '0 : cnt_r + CW'(1);
      end

      if (scan_st && proc) begin
        if (flags.match && !hit_r) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= ridx;
          hit_rank_r <= rank_rd;
          hu_r       <= e_ku;
          hl_r       <= e_kl;
          hk_r       <= e_kk;
        end
        if (!valid_r[ridx] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= ridx;
        end
        if (flags.above) begin
          max_idx_r  <= ridx;
          max_rank_r <= rank_rd;
        end
      end

      if (decide_st) begin
        s_r     <= s_nxt;
        limit_r <= limit_nxt;
        down_r  <= (lrks_pkg::kind_t'(kind_r) == lrks_pkg::KIND_DELETE);
        found_r <= hit_r && (lrks_pkg::kind_t'(kind_r) != lrks_pkg::KIND_NONE);
        if (lrks_pkg::kind_t'(kind_r) == lrks_pkg::KIND_LOOKUP && hit_r) begin
          ou_r <= hu_r;
          ol_r <= hl_r;
          ok_r <= hk_r;
        end else begin
          ou_r <= '0;
          ol_r <= '0;
          ok_r <= '0;
        end
        if (lrks_pkg::kind_t'(kind_r) == lrks_pkg::KIND_PUT) begin
          valid_r[s_nxt] <= 1'b1;
        end else if (lrks_pkg::kind_t'(kind_r) == lrks_pkg::KIND_DELETE && hit_r) begin
          valid_r[s_nxt] <= 1'b0;
        end
      end
    end
  end

endmodule
